// ===== design/plte_pkg.sv =====
// shared types and codes for the piecewise-linear table evaluator
`timescale 1ns / 1ps
`default_nettype none

package plte_pkg;

    typedef enum logic [1:0] {
        OP_FIRST = 2'd0,
        OP_NEXT  = 2'd1,
        OP_EVAL  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_UNLOADED = 2'd3
    } status_t;

    localparam logic [1:0] CFG_RANGE_START  = 2'd0;
    localparam logic [1:0] CFG_RANGE_END    = 2'd1;
    localparam logic [1:0] CFG_STEP_SIZE    = 2'd2;
    localparam logic [1:0] CFG_INVERSE_STEP = 2'd3;

endpackage

`default_nettype wire

// ===== design/plte_ram.sv =====
// single-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module plte_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/piecewise_linear_table_eval.sv =====
// top level: piecewise-linear table builder and evaluator on one shared multiplier
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_op, s_sample_value, s_x_value
//   m_       out        m_valid/m_ready    m_y_value, m_status
//   cfg_     in         cfg_we             cfg_index, cfg_data
//
// steps per item, from accept until ready again; the result turns valid as s_ready rises
// restart, unused op and table-full load: no multiplier pass, straight to the result
// segment load: two passes through the multiplier, then the table write
// evaluate: multiply, table read, multiply; no read or second multiply for an unloaded segment
// one item at a time; the result register lets the next item in while a result waits,
// a second finished item holds in the last state until that register empties
// reset is synchronous; the tables are not cleared, only the segment count, previous sample and start x

`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_table_eval #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_op,
    input  wire logic signed [15:0] s_sample_value,
    input  wire logic signed [15:0] s_x_value,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_y_value,
    output logic [1:0]              m_status
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    // segment start x stays below 2^16 * (depth + 1)
    localparam int SSX_W = 17 + $clog2(TABLE_DEPTH + 1);
    localparam int A_W   = 32;
    localparam int PW    = A_W + SSX_W;
    localparam int SUM_W = PW - 7;

    localparam logic signed [SUM_W-1:0] SUM_MAX32 = SUM_W'(64'sh7FFFFFFF);
    localparam logic signed [SUM_W-1:0] SUM_MIN32 = SUM_W'(-64'sh80000000);
    localparam logic signed [SUM_W-1:0] SUM_MAX16 = SUM_W'(64'sh7FFF);
    localparam logic signed [SUM_W-1:0] SUM_MIN16 = SUM_W'(-64'sh8000);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_LOAD_WR,
        S_EVAL_IDX,
        S_EVAL_MUL,
        S_EVAL_Y,
        S_DONE
    } state_t;

    // configuration
    logic signed [15:0] range_start_reg;
    logic signed [15:0] range_end_reg;
    logic [15:0]        step_reg;
    logic [15:0]        inv_reg;

    // sequencer and table state
    state_t               state_reg;
    plte_pkg::op_t        op_reg;
    logic signed [15:0]   sample_reg;
    logic signed [15:0]   x_reg;
    logic signed [15:0]   prev_reg;
    logic signed [SSX_W-1:0] ssx_reg;
    logic [CNT_W-1:0]     count_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [31:0]   slope_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 oor_reg;
    logic signed [15:0]   res_y_reg;
    plte_pkg::status_t    res_st_reg;

    // result register
    logic                 m_valid_reg;
    logic signed [15:0]   m_y_reg;
    plte_pkg::status_t    m_st_reg;

    // datapath
    logic signed [16:0]      diff;
    logic signed [16:0]      rel;
    logic signed [31:0]      slope_new;
    logic signed [A_W-1:0]   mult_a;
    logic signed [SSX_W-1:0] mult_b;
    logic signed [PW-1:0]    mult_p;
    logic signed [SUM_W-1:0] icpt_full;
    logic signed [SUM_W-1:0] y_full;
    logic signed [31:0]      icpt_sat;
    logic signed [15:0]      y_sat;
    logic [15:0]             idx_full;
    logic [IDX_W-1:0]        eval_idx;
    logic                    eval_oor;
    logic                    eval_loaded;

    // table ram: slope in the upper half, intercept in the lower
    logic                 ram_we;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_addr;
    logic [63:0]          ram_wdata;
    logic [63:0]          ram_rdata;
    logic signed [31:0]   tab_slope;
    logic signed [31:0]   tab_icpt;

    assign diff      = 17'(sample_reg) - 17'(prev_reg);
    assign rel       = 17'(x_reg) - 17'(range_start_reg);
    assign slope_new = 32'($signed(prod_reg[32:8]));
    assign tab_slope = $signed(ram_rdata[63:32]);
    assign tab_icpt  = $signed(ram_rdata[31:0]);

    always_comb begin
        mult_a = '0;
        mult_b = '0;
        case (state_reg)
            S_MUL1: begin
                mult_a = (op_reg == plte_pkg::OP_EVAL) ? A_W'(rel) : A_W'(diff);
                mult_b = SSX_W'($signed({1'b0, inv_reg}));
            end
            S_MUL2: begin
                mult_a = slope_new;
                mult_b = ssx_reg;
            end
            S_EVAL_MUL: begin
                mult_a = tab_slope;
                mult_b = SSX_W'(x_reg);
            end
            default: begin
                mult_a = '0;
                mult_b = '0;
            end
        endcase
    end

    assign mult_p = mult_a * mult_b;

    // floor shift is the arithmetic shift of the product
    assign icpt_full = SUM_W'(prev_reg) - SUM_W'($signed(prod_reg[PW-1:8]));
    assign y_full    = SUM_W'($signed(prod_reg[PW-1:8])) + SUM_W'(tab_icpt);

    always_comb begin
        if (icpt_full > SUM_MAX32) begin
            icpt_sat = 32'sh7FFFFFFF;
        end else if (icpt_full < SUM_MIN32) begin
            icpt_sat = -32'sh80000000;
        end else begin
            icpt_sat = icpt_full[31:0];
        end
        if (y_full > SUM_MAX16) begin
            y_sat = 16'sh7FFF;
        end else if (y_full < SUM_MIN16) begin
            y_sat = -16'sh8000;
        end else begin
            y_sat = y_full[15:0];
        end
    end

    // segment index from (x - start) * inverse_step
    assign idx_full = prod_reg[31:16];

    always_comb begin
        eval_oor = 1'b0;
        if (rel[16]) begin
            eval_idx = '0;
            eval_oor = 1'b1;
        end else if (idx_full >= 16'(TABLE_DEPTH)) begin
            eval_idx = IDX_W'(TABLE_DEPTH - 1);
            eval_oor = 1'b1;
        end else begin
            eval_idx = idx_full[IDX_W-1:0];
        end
        if (x_reg > range_end_reg) begin
            eval_oor = 1'b1;
        end
        eval_loaded = CNT_W'(eval_idx) < count_reg;
    end

    assign ram_we    = (state_reg == S_LOAD_WR);
    assign ram_re    = (state_reg == S_EVAL_IDX) && eval_loaded;
    assign ram_addr  = ram_we ? count_reg[IDX_W-1:0] : eval_idx;
    assign ram_wdata = {slope_reg, icpt_sat};

    plte_ram #(
        .WIDTH (64),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_start_reg <= '0;
            range_end_reg   <= 16'sh7FFF;
            step_reg        <= 16'd256;
            inv_reg         <= 16'd256;
        end else if (cfg_we) begin
            case (cfg_index)
                plte_pkg::CFG_RANGE_START:  range_start_reg <= $signed(cfg_data);
                plte_pkg::CFG_RANGE_END:    range_end_reg   <= $signed(cfg_data);
                plte_pkg::CFG_STEP_SIZE:    step_reg        <= cfg_data;
                plte_pkg::CFG_INVERSE_STEP: inv_reg         <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            prev_reg    <= '0;
            ssx_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // the done state loads the result register itself
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg     <= plte_pkg::op_t'(s_op);
                        sample_reg <= s_sample_value;
                        x_reg      <= s_x_value;
                        res_y_reg  <= '0;
                        res_st_reg <= (plte_pkg::op_t'(s_op) == plte_pkg::OP_NEXT &&
                                       count_reg == CNT_W'(TABLE_DEPTH)) ?
                                      plte_pkg::ST_FULL : plte_pkg::ST_OK;
                        case (plte_pkg::op_t'(s_op))
                            plte_pkg::OP_FIRST: begin
                                prev_reg  <= s_sample_value;
                                ssx_reg   <= SSX_W'(range_start_reg);
                                count_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            plte_pkg::OP_NEXT: begin
                                if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                                    state_reg <= S_DONE;
                                end else begin
                                    state_reg <= S_MUL1;
                                end
                            end
                            plte_pkg::OP_EVAL: begin
                                state_reg <= S_MUL1;
                            end
                            default: begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_MUL1: begin
                    prod_reg  <= mult_p;
                    state_reg <= (op_reg == plte_pkg::OP_EVAL) ? S_EVAL_IDX : S_MUL2;
                end
                S_MUL2: begin
                    prod_reg  <= mult_p;
                    slope_reg <= slope_new;
                    state_reg <= S_LOAD_WR;
                end
                S_LOAD_WR: begin
                    ssx_reg   <= ssx_reg + SSX_W'($signed({1'b0, step_reg}));
                    prev_reg  <= sample_reg;
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= S_DONE;
                end
                S_EVAL_IDX: begin
                    idx_reg <= eval_idx;
                    oor_reg <= eval_oor;
                    if (eval_loaded) begin
                        state_reg <= S_EVAL_MUL;
                    end else begin
                        res_st_reg <= plte_pkg::ST_UNLOADED;
                        state_reg  <= S_DONE;
                    end
                end
                S_EVAL_MUL: begin
                    prod_reg  <= mult_p;
                    state_reg <= S_EVAL_Y;
                end
                S_EVAL_Y: begin
                    res_y_reg  <= y_sat;
                    res_st_reg <= oor_reg ? plte_pkg::ST_RANGE : plte_pkg::ST_OK;
                    state_reg  <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_y_reg     <= res_y_reg;
                        m_st_reg    <= res_st_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_y_value = m_y_reg;
    assign m_status  = m_st_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("segment count beyond table depth");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken while one is in work");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (count_reg < CNT_W'(TABLE_DEPTH)))
        else $error("table write with table full");

    a_unloaded_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == plte_pkg::ST_UNLOADED) |-> (m_y_value == 16'sd0))
        else $error("unloaded segment result not zero");

    a_eval_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL_MUL) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("read of a segment never written");

endmodule

`default_nettype wire

// ===== tb/piecewise_linear_table_eval_test.sv =====
// testbench for the piecewise-linear table evaluator: directed cases, then random table traffic
`timescale 1ns / 1ps

module piecewise_linear_table_eval_test;

    localparam int TABLE_DEPTH = 64;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [15:0] y;
        plte_pkg::status_t  status;
    } result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = plte_pkg::CFG_RANGE_START;
    logic [15:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_op = plte_pkg::OP_NONE;
    logic signed [15:0] s_sample_value = '0;
    logic signed [15:0] s_x_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_y_value;
    logic [1:0]         m_status;

    piecewise_linear_table_eval #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_sample_value(s_sample_value),
        .s_x_value     (s_x_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_y_value     (m_y_value),
        .m_status      (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predicted table contents and register copies
    logic signed [31:0] slope_mem [TABLE_DEPTH];
    logic signed [31:0] icpt_mem [TABLE_DEPTH];
    logic signed [15:0] last_sample = '0;
    logic signed [31:0] next_start_x = '0;
    int                 seg_count = 0;
    logic signed [15:0] cfg_start = 16'sd0;
    logic signed [15:0] cfg_end = 16'sh7fff;
    logic [15:0]        cfg_step = 16'd256;
    logic [15:0]        cfg_inv = 16'd256;

    result_t pending [$];
    int      items_sent = 0;
    int      results_checked = 0;
    int      mismatch_count = 0;
    int      op_count [4] = '{0, 0, 0, 0};
    int      status_count [4] = '{0, 0, 0, 0};
    bit      sender_idles = 1'b1;
    bit      receiver_stalls = 1'b1;

    function automatic longint sat32(longint v);
        if (v > I32_MAX) return I32_MAX;
        if (v < I32_MIN) return I32_MIN;
        return v;
    endfunction

    function automatic result_t predict_result(plte_pkg::op_t op, logic signed [15:0] sample,
                                               logic signed [15:0] x);
        result_t r;
        longint  diff, slope, icpt, rel, idx, acc;
        bit      out_of_range;
        r.y = '0;
        r.status = plte_pkg::ST_OK;
        case (op)
            plte_pkg::OP_FIRST: begin
                last_sample = sample;
                next_start_x = cfg_start;
                seg_count = 0;
            end
            plte_pkg::OP_NEXT: begin
                if (seg_count >= TABLE_DEPTH) begin
                    r.status = plte_pkg::ST_FULL;
                end else begin
                    diff = longint'(sample) - longint'(last_sample);
                    slope = (diff * longint'(cfg_inv)) >>> 8;
                    icpt = longint'(last_sample) - ((slope * longint'(next_start_x)) >>> 8);
                    slope_mem[seg_count] = 32'(sat32(slope));
                    icpt_mem[seg_count] = 32'(sat32(icpt));
                    next_start_x = 32'(sat32(longint'(next_start_x) + longint'(cfg_step)));
                    last_sample = sample;
                    seg_count++;
                end
            end
            plte_pkg::OP_EVAL: begin
                out_of_range = 1'b0;
                rel = longint'(x) - longint'(cfg_start);
                if (rel < 0) begin
                    idx = 0;
                    out_of_range = 1'b1;
                end else begin
                    idx = (rel * longint'(cfg_inv)) >>> 16;
                    if (idx >= TABLE_DEPTH) begin
                        idx = TABLE_DEPTH - 1;
                        out_of_range = 1'b1;
                    end
                end
                if (x > cfg_end) out_of_range = 1'b1;
                // an unloaded segment wins over the range flag
                if (idx >= seg_count) begin
                    r.status = plte_pkg::ST_UNLOADED;
                end else begin
                    acc = ((longint'(slope_mem[idx]) * longint'(x)) >>> 8)
                        + longint'(icpt_mem[idx]);
                    if (acc > 32767) r.y = 16'sh7fff;
                    else if (acc < -32768) r.y = 16'sh8000;
                    else r.y = 16'(acc);
                    r.status = out_of_range ? plte_pkg::ST_RANGE : plte_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic send_item(input plte_pkg::op_t op, input logic signed [15:0] sample,
                             input logic signed [15:0] x);
        int gap;
        gap = sender_idles ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_op = op;
        s_sample_value = sample;
        s_x_value = x;
        do @(posedge aclk); while (!s_ready);
        pending.push_back(predict_result(op, sample, x));
        items_sent++;
        op_count[op]++;
    endtask

    // stop sending and wait until the block has nothing left in flight
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending.size() != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        drain_results();
        cfg_we = 1'b1;
        cfg_index = index;
        cfg_data = value;
        case (index)
            plte_pkg::CFG_RANGE_START:  cfg_start = value;
            plte_pkg::CFG_RANGE_END:    cfg_end = value;
            plte_pkg::CFG_STEP_SIZE:    cfg_step = value;
            plte_pkg::CFG_INVERSE_STEP: cfg_inv = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [15:0] random16();
        return 16'($urandom);
    endfunction

    // x mostly inside the loaded part of the grid
    function automatic logic signed [15:0] pick_x();
        int rel, xv;
        if ($urandom_range(0, 9) < 7) begin
            rel = $urandom_range(0, (seg_count + 1) * int'(cfg_step));
            xv = int'(cfg_start) + rel;
            if (xv > 32767) xv = 32767;
            return 16'(xv);
        end
        return random16();
    endfunction

    // either arbitrary or close to the previous sample
    function automatic logic signed [15:0] next_sample();
        int d, v;
        if ($urandom_range(0, 1) == 0) return random16();
        d = $urandom_range(0, 1024);
        v = int'(last_sample) + d - 512;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    task automatic send_noise();
        send_item(plte_pkg::op_t'($urandom_range(0, 3)), random16(), random16());
    endtask

    // result side: random stalls at the falling edge
    initial begin : drive_ready
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (!receiver_stalls) begin
                m_ready = 1'b1;
                stall_left = 0;
            end else if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
                if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending.size() == 0) begin
                report_mismatch($sformatf("result with no item waiting: y %0d status %0d",
                                          m_y_value, m_status));
            end else begin
                want = pending.pop_front();
                if (m_y_value !== want.y)
                    report_mismatch($sformatf("result %0d y_value got %0d want %0d",
                                              results_checked, m_y_value, want.y));
                if (m_status !== want.status)
                    report_mismatch($sformatf("result %0d status got %0d want %0d",
                                              results_checked, m_status, want.status));
                status_count[want.status]++;
                results_checked++;
            end
        end
    end

    task automatic test_before_restart();
        send_item(plte_pkg::OP_EVAL, 16'sd0, 16'sd0);
        // load with reset values: previous sample 0, start x 0
        send_item(plte_pkg::OP_NEXT, 16'sd256, 16'sd0);
        send_item(plte_pkg::OP_EVAL, 16'sd0, 16'sd128);
        send_item(plte_pkg::OP_EVAL, 16'sd0, -16'sd1);
        send_item(plte_pkg::OP_EVAL, 16'sd0, 16'sh7fff);
        send_item(plte_pkg::OP_NONE, 16'sh8000, 16'sh7fff);
    endtask

    task automatic test_field_extremes();
        write_register(plte_pkg::CFG_RANGE_START, 16'h8000);
        write_register(plte_pkg::CFG_RANGE_END, 16'h7fff);
        write_register(plte_pkg::CFG_STEP_SIZE, 16'hffff);
        write_register(plte_pkg::CFG_INVERSE_STEP, 16'd1);
        send_item(plte_pkg::OP_FIRST, 16'sh8000, 16'sh7fff);
        send_item(plte_pkg::OP_NEXT, 16'sh7fff, 16'sh8000);
        send_item(plte_pkg::OP_EVAL, 16'sh7fff, 16'sh8000);
        send_item(plte_pkg::OP_EVAL, 16'sh8000, 16'sh7fff);
        send_item(plte_pkg::OP_EVAL, 16'sd0, 16'sd0);
        write_register(plte_pkg::CFG_RANGE_START, 16'h7fff);
        write_register(plte_pkg::CFG_RANGE_END, 16'h8000);
        write_register(plte_pkg::CFG_STEP_SIZE, 16'd1);
        write_register(plte_pkg::CFG_INVERSE_STEP, 16'hffff);
        send_item(plte_pkg::OP_FIRST, 16'sh7fff, 16'sd0);
        send_item(plte_pkg::OP_NEXT, 16'sh8000, 16'sd0);
        send_item(plte_pkg::OP_NEXT, 16'sh7fff, 16'sd0);
        send_item(plte_pkg::OP_EVAL, 16'sd0, 16'sh7fff);
        send_item(plte_pkg::OP_EVAL, 16'sd0, 16'sh8000);
        send_item(plte_pkg::OP_EVAL, 16'sd0, 16'sh7ffe);
    endtask

    task automatic test_table_full();
        write_register(plte_pkg::CFG_RANGE_START, 16'hc000);
        write_register(plte_pkg::CFG_RANGE_END, 16'h7fff);
        write_register(plte_pkg::CFG_STEP_SIZE, 16'd256);
        write_register(plte_pkg::CFG_INVERSE_STEP, 16'd256);
        send_item(plte_pkg::OP_FIRST, random16(), random16());
        repeat (TABLE_DEPTH + 2) send_item(plte_pkg::OP_NEXT, next_sample(), random16());
        repeat (12) send_item(plte_pkg::OP_EVAL, random16(), pick_x());
    endtask

    // tables stay, registers move under them
    task automatic test_config_after_load();
        write_register(plte_pkg::CFG_RANGE_START, 16'd0);
        write_register(plte_pkg::CFG_STEP_SIZE, 16'd256);
        write_register(plte_pkg::CFG_INVERSE_STEP, 16'd256);
        send_item(plte_pkg::OP_FIRST, random16(), random16());
        repeat (10) send_item(plte_pkg::OP_NEXT, next_sample(), random16());
        write_register(plte_pkg::CFG_INVERSE_STEP, 16'd512);
        write_register(plte_pkg::CFG_RANGE_START, 16'hff00);
        write_register(plte_pkg::CFG_RANGE_END, 16'd1024);
        repeat (10) send_item(plte_pkg::OP_EVAL, random16(), pick_x());
    endtask

    task automatic randomize_config();
        int r;
        logic [15:0] step, inv;
        logic [15:0] start;
        r = $urandom_range(0, 9);
        if (r == 0) step = 16'd1;
        else if (r == 1) step = 16'hffff;
        else if (r < 6) step = 16'(1 << $urandom_range(2, 11));
        else step = 16'($urandom_range(1, 65535));
        inv = (65536 / int'(step) > 65535) ? 16'hffff : 16'(65536 / int'(step));
        if ($urandom_range(0, 4) == 0) inv = 16'($urandom_range(1, 65535));
        r = $urandom_range(0, 9);
        if (r == 0) start = 16'h8000;
        else if (r == 1) start = 16'h7fff;
        else if (r < 4) start = random16();
        else start = 16'($urandom_range(0, 24576) - 16384);
        if ($urandom_range(0, 4) != 0) write_register(plte_pkg::CFG_STEP_SIZE, step);
        if ($urandom_range(0, 4) != 0) write_register(plte_pkg::CFG_INVERSE_STEP, inv);
        if ($urandom_range(0, 4) != 0) write_register(plte_pkg::CFG_RANGE_START, start);
        r = $urandom_range(0, 9);
        if (r < 4) write_register(plte_pkg::CFG_RANGE_END, 16'h7fff);
        else if (r == 4) write_register(plte_pkg::CFG_RANGE_END, 16'h8000);
        else if (r < 8) write_register(plte_pkg::CFG_RANGE_END, random16());
    endtask

    task automatic run_sequence();
        int r, loads;
        r = $urandom_range(0, 9);
        if (r < 8) begin
            r = $urandom_range(0, 9);
            if (r < 6) loads = $urandom_range(1, 12);
            else if (r < 9) loads = $urandom_range(13, 40);
            else loads = $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 4);
            send_item(plte_pkg::OP_FIRST, random16(), random16());
            repeat (loads) begin
                if ($urandom_range(0, 19) == 0) send_noise();
                else send_item(plte_pkg::OP_NEXT, next_sample(), random16());
            end
        end
        repeat ($urandom_range(3, 16)) begin
            if ($urandom_range(0, 19) == 0) send_noise();
            else send_item(plte_pkg::OP_EVAL, random16(), pick_x());
        end
    endtask

    task automatic test_random_traffic(input int target);
        int goal;
        goal = items_sent + target;
        while (items_sent < goal) begin
            randomize_config();
            // some phases run without any idling
            sender_idles = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 5)) run_sequence();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_before_restart();
        test_field_extremes();
        test_table_full();
        test_config_after_load();
        test_random_traffic(1350);
        drain_results();
        repeat (20) @(posedge aclk);
        $display("sent %0d items: %0d restarts, %0d loads, %0d evaluates, %0d unused ops",
                 items_sent, op_count[plte_pkg::OP_FIRST], op_count[plte_pkg::OP_NEXT],
                 op_count[plte_pkg::OP_EVAL], op_count[plte_pkg::OP_NONE]);
        $display("checked %0d results: %0d ok, %0d out of range, %0d full, %0d not loaded",
                 results_checked, status_count[plte_pkg::ST_OK],
                 status_count[plte_pkg::ST_RANGE], status_count[plte_pkg::ST_FULL],
                 status_count[plte_pkg::ST_UNLOADED]);
        if (mismatch_count == 0 && pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
